// ===== design/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, quiet while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also runs through reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/brfr_pkg.sv =====
package brfr_pkg;

  localparam int REPLY_DEPTH_DEF = 64;
  localparam int FRAME_DEPTH_DEF = 1024;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int OUT_TUSER_W = 3;
  localparam int POS_W       = 10;
  localparam int PAD_W       = OUT_TDATA_W - POS_W - 8;
  localparam int POS_MAX     = 1023;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_W       = 8;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] CFG_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_END   = 1'b1;

  localparam logic [7:0] START_RESET = 8'h68;
  localparam logic [7:0] END_RESET   = 8'h16;

  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_K     = 8'h4B;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_I     = 8'h49;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG7  = 8'h37;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;

  localparam logic [4:0] LEN_A = 5'd16;
  localparam logic [4:0] LEN_L = 5'd3;
  localparam logic [4:0] LEN_S = 5'd4;

  // offsets inside the reply store for a discovery line
  localparam int ADDR_OFS = 10;
  localparam int TAG_OFS  = 17;
  localparam int NAME_OFS = 22;
  localparam int NAME_MAX = 42;

  localparam logic [2:0] TAG_LAST  = 3'd4;
  localparam logic [1:0] ADDR_LAST = 2'd3;

  typedef enum logic [2:0] {
    EV_CONSUMED,
    EV_FRAME_BYTE,
    EV_FRAME_DONE,
    EV_MSG_BYTE,
    EV_MSG_DONE,
    EV_RECORD_BYTE,
    EV_OVERFLOW
  } event_t;

  typedef enum logic [2:0] {
    RP_IDLE,
    RP_O,
    RP_OK,
    RP_OKP,
    RP_COLLECT,
    RP_TO_CR
  } reply_phase_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_D,
    DP_I,
    DP_S,
    DP_BODY
  } disc_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PEND,
    ST_CHK_RD,
    ST_CHK_DAT,
    ST_NOMATCH,
    ST_NAME_RD,
    ST_NAME_DAT,
    ST_OPEN,
    ST_ADDR_RD,
    ST_ADDR_DAT,
    ST_CLOSE
  } seq_state_t;

  typedef struct packed {
    event_t           ev;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
  } result_t;

  // "NAME:" tag expected before the device name
  function automatic logic [7:0] tag_char(logic [2:0] j);
    logic [7:0] c;
    unique case (j)
      3'd0:    c = CH_N;
      3'd1:    c = CH_A;
      3'd2:    c = CH_M;
      3'd3:    c = CH_E;
      default: c = CH_COLON;
    endcase
    return c;
  endfunction

endpackage

// ===== design/ble_reply_and_frame_receiver_unit.sv =====
// Results: a word's first result is registered on acceptance and appears in the
//   next cycle; a second one waits in pend until the output is free (ST_PEND).
// Throughput: one word per cycle while results are one per word and the output is
//   not stalled; input is held off while a second result waits and, after a
//   discovery line end, while the stored tag is checked and the record is sent.
// Reset (rst, synchronous): clears phases, the reply index, frame state, the store
//   valid bits and the output valid flag; registers return to 0x68 and 0x16 at once.
module ble_reply_and_frame_receiver_unit #(
  parameter int REPLY_DEPTH = brfr_pkg::REPLY_DEPTH_DEF,
  parameter int FRAME_DEPTH = brfr_pkg::FRAME_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [brfr_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] rx_byte
  input  logic                             s_tuser,   // [0] action
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [brfr_pkg::OUT_TDATA_W-1:0] m_tdata,   // [7:0] data_byte, [17:8] position
  output logic [brfr_pkg::OUT_TUSER_W-1:0] m_tuser,   // [2:0] event_res
  output logic                             m_tlast,
  input  logic                             cfg_wr_en,
  input  logic [brfr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brfr_pkg::CFG_W-1:0]       cfg_data
);
  import brfr_pkg::*;

  localparam int RAW = $clog2(REPLY_DEPTH);
  localparam int RIW = $clog2(REPLY_DEPTH + 1);
  localparam int FCW = $clog2(FRAME_DEPTH + 1);
  localparam logic [RIW-1:0] RDEPTH    = RIW'(REPLY_DEPTH);
  localparam logic [RAW-1:0] TAG_ADDR  = RAW'(TAG_OFS);
  localparam logic [RAW-1:0] NAME_ADDR = RAW'(NAME_OFS);
  localparam logic [RAW-1:0] ADDR_ADDR = RAW'(ADDR_OFS);
  localparam logic [5:0]     NAME_LAST = 6'(NAME_MAX - 1);

  function automatic logic [POS_W-1:0] sat_pos(logic [FCW-1:0] v);
    return (32'(v) > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(v);
  endfunction

  // configuration
  logic [7:0] start_byte, end_byte;

  // parser and frame state
  reply_phase_t   reply_phase, reply_phase_next;
  disc_phase_t    disc_phase, disc_phase_next;
  logic [4:0]     target_len, target_len_next;
  logic [RIW-1:0] reply_index, reply_index_next;
  logic           frame_active, frame_active_next;
  logic [FCW-1:0] frame_count, frame_count_next;
  logic [15:0]    frame_len, frame_len_next;

  // reply store
  logic [7:0]             store_mem [REPLY_DEPTH];
  logic [REPLY_DEPTH-1:0] store_vld;
  logic [7:0]             rd_data, rd_byte;
  logic                   rd_vld, rd_en;
  logic [RAW-1:0]         rd_addr, mem_waddr;
  logic                   mem_we, do_store;

  // sequencer and output
  seq_state_t     state, state_next;
  logic [2:0]     chk_idx, chk_idx_next;
  logic           mism, mism_next;
  logic [RIW-1:0] done_pos, done_pos_next;
  logic [RAW-1:0] name_ptr, name_ptr_next;
  logic [RAW:0]   p_inc;
  logic [5:0]     rec_idx, rec_idx_next;
  logic [1:0]     addr_k, addr_k_next;
  result_t        r0, r1, pend, out_q, out_val;
  logic           has_r1, start_chk;
  logic           out_load, pend_load, out_last_val, out_last_q, out_valid, out_free;
  logic           accept;

  logic [7:0]     b;
  logic           st_ok;
  logic [RIW-1:0] st_idx;
  result_t        st_res;

  assign b         = s_tdata[7:0];
  assign st_ok     = reply_index < RDEPTH;
  assign st_idx    = st_ok ? reply_index + RIW'(1) : reply_index;
  assign st_res    = st_ok ? result_t'{EV_MSG_BYTE, b, POS_W'(reply_index)}
                           : result_t'{EV_OVERFLOW, b, POS_W'(reply_index)};
  assign mem_waddr = reply_index[RAW-1:0];
  assign mem_we    = accept && do_store && st_ok;
  assign rd_byte   = rd_vld ? rd_data : 8'h00;
  assign p_inc     = (RAW+1)'(name_ptr) + (RAW+1)'(1);

  assign out_free = !out_valid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign m_tvalid = out_valid;
  assign m_tdata  = {{PAD_W{1'b0}}, out_q.pos, out_q.data};
  assign m_tuser  = out_q.ev;
  assign m_tlast  = out_last_q;

  // one accepted word: parser and frame tracker
  always_comb begin : step
    logic           fa;
    logic [FCW-1:0] cnt;
    logic [15:0]    len;
    reply_phase_next  = reply_phase;
    disc_phase_next   = disc_phase;
    target_len_next   = target_len;
    reply_index_next  = reply_index;
    frame_active_next = frame_active;
    frame_count_next  = frame_count;
    frame_len_next    = frame_len;
    r0        = result_t'{EV_CONSUMED, b, POS_W'(0)};
    r1        = result_t'{EV_CONSUMED, b, POS_W'(0)};
    has_r1    = 1'b0;
    do_store  = 1'b0;
    start_chk = 1'b0;
    fa        = frame_active;
    cnt       = frame_count;
    len       = frame_len;
    if (s_tuser) begin
      // release: drop any open or held frame
      frame_active_next = 1'b0;
      frame_count_next  = '0;
      r0 = result_t'{EV_CONSUMED, 8'h00, POS_W'(0)};
    end else if (!frame_active && frame_count != '0) begin
      // frame held: ignore the word
      r0 = result_t'{EV_CONSUMED, b, POS_W'(0)};
    end else begin
      if (!frame_active) begin
        if (b == start_byte) begin
          fa = 1'b1;
        end else begin
          unique case (reply_phase)
            RP_O: begin
              reply_phase_next = (b == CH_K) ? RP_OK : RP_IDLE;
            end
            RP_OK: begin
              reply_phase_next = (b == CH_PLUS) ? RP_OKP : RP_IDLE;
            end
            RP_OKP: begin
              reply_phase_next = RP_COLLECT;
              if (b == CH_A) target_len_next = LEN_A;
              else if (b == CH_L || b == CH_C) target_len_next = LEN_L;
              else if (b == CH_S) target_len_next = LEN_S;
              else if (b == CH_N) reply_phase_next = RP_TO_CR;
              else if (b == CH_D) disc_phase_next = DP_D;
              else reply_phase_next = RP_IDLE;
            end
            RP_COLLECT: begin
              if (disc_phase != DP_NONE) begin
                if (b == CH_I) begin
                  disc_phase_next = DP_I;
                end else if (b == CH_S && disc_phase == DP_I) begin
                  disc_phase_next = DP_S;
                end else if (b >= CH_DIG0 && b <= CH_DIG7 && disc_phase == DP_S) begin
                  disc_phase_next  = DP_BODY;
                  do_store         = 1'b1;
                  r0               = st_res;
                  reply_index_next = st_idx;
                end else if (disc_phase == DP_BODY) begin
                  do_store = 1'b1;
                  if (b != CH_CR) begin
                    r0               = st_res;
                    reply_index_next = st_idx;
                  end else begin
                    // store CR silently, then check the tag from the store
                    reply_phase_next = RP_IDLE;
                    disc_phase_next  = DP_NONE;
                    reply_index_next = '0;
                    start_chk        = 1'b1;
                  end
                end else begin
                  reply_phase_next = RP_IDLE;
                  disc_phase_next  = DP_NONE;
                end
              end else begin
                do_store = 1'b1;
                r0       = st_res;
                if (32'(st_idx) >= 32'(target_len)) begin
                  has_r1           = 1'b1;
                  r1               = result_t'{EV_MSG_DONE, b, POS_W'(st_idx)};
                  reply_phase_next = RP_IDLE;
                  reply_index_next = '0;
                end else begin
                  reply_index_next = st_idx;
                end
              end
            end
            RP_TO_CR: begin
              do_store = 1'b1;
              r0       = st_res;
              if (b == CH_CR) begin
                has_r1           = 1'b1;
                r1               = result_t'{EV_MSG_DONE, b, POS_W'(st_idx)};
                reply_phase_next = RP_IDLE;
                reply_index_next = '0;
              end else begin
                reply_index_next = st_idx;
              end
            end
            default: begin
              reply_phase_next = (b == CH_O) ? RP_O : RP_IDLE;
            end
          endcase
        end
      end
      if (fa) begin
        if (32'(frame_count) < FRAME_DEPTH) begin
          if (frame_count == FCW'(3)) len[7:0] = b;
          if (frame_count == FCW'(4)) len[15:8] = b;
          r0  = result_t'{EV_FRAME_BYTE, b, sat_pos(frame_count)};
          cnt = frame_count + FCW'(1);
        end else begin
          r0 = result_t'{EV_OVERFLOW, b, sat_pos(frame_count)};
        end
        if (32'(cnt) > 32'd5 && 32'(cnt) > 32'(len) + 32'd5 && b == end_byte) begin
          fa     = 1'b0;
          has_r1 = 1'b1;
          r1     = result_t'{EV_FRAME_DONE, b, sat_pos(cnt)};
        end
        frame_count_next = cnt;
        frame_len_next   = len;
      end
      frame_active_next = fa;
    end
  end

  // output sequencing and record walk over the store
  always_comb begin : seq
    state_next    = state;
    out_load      = 1'b0;
    out_val       = r0;
    out_last_val  = 1'b1;
    pend_load     = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = TAG_ADDR;
    chk_idx_next  = chk_idx;
    mism_next     = mism;
    done_pos_next = done_pos;
    name_ptr_next = name_ptr;
    rec_idx_next  = rec_idx;
    addr_k_next   = addr_k;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (start_chk) begin
            state_next    = ST_CHK_RD;
            chk_idx_next  = '0;
            mism_next     = 1'b0;
            done_pos_next = st_idx;
          end else begin
            out_load     = 1'b1;
            out_val      = r0;
            out_last_val = !has_r1;
            if (has_r1) begin
              pend_load  = 1'b1;
              state_next = ST_PEND;
            end
          end
        end
      end
      ST_PEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val    = pend;
          state_next = ST_IDLE;
        end
      end
      ST_CHK_RD: begin
        rd_en      = 1'b1;
        rd_addr    = TAG_ADDR + RAW'(chk_idx);
        state_next = ST_CHK_DAT;
      end
      ST_CHK_DAT: begin
        mism_next = mism | (rd_byte != tag_char(chk_idx));
        if (chk_idx == TAG_LAST) begin
          name_ptr_next = NAME_ADDR;
          rec_idx_next  = '0;
          state_next    = mism_next ? ST_NOMATCH : ST_NAME_RD;
        end else begin
          chk_idx_next = chk_idx + 3'd1;
          state_next   = ST_CHK_RD;
        end
      end
      ST_NOMATCH: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val    = result_t'{EV_MSG_DONE, CH_CR, POS_W'(done_pos)};
          state_next = ST_IDLE;
        end
      end
      ST_NAME_RD: begin
        rd_en      = 1'b1;
        rd_addr    = name_ptr;
        state_next = ST_NAME_DAT;
      end
      ST_NAME_DAT: begin
        // a CR ends the name, but never before its first byte
        if (rec_idx != '0 && rd_byte == CH_CR) begin
          state_next = ST_OPEN;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_val      = result_t'{EV_RECORD_BYTE, rd_byte, POS_W'(rec_idx)};
          out_last_val = 1'b0;
          rec_idx_next = rec_idx + 6'd1;
          if (32'(p_inc) >= REPLY_DEPTH || rec_idx == NAME_LAST) begin
            state_next = ST_OPEN;
          end else begin
            name_ptr_next = p_inc[RAW-1:0];
            state_next    = ST_NAME_RD;
          end
        end
      end
      ST_OPEN: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_val      = result_t'{EV_RECORD_BYTE, CH_LPAR, POS_W'(rec_idx)};
          out_last_val = 1'b0;
          rec_idx_next = rec_idx + 6'd1;
          addr_k_next  = '0;
          state_next   = ST_ADDR_RD;
        end
      end
      ST_ADDR_RD: begin
        rd_en      = 1'b1;
        rd_addr    = ADDR_ADDR + RAW'(addr_k);
        state_next = ST_ADDR_DAT;
      end
      ST_ADDR_DAT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_val      = result_t'{EV_RECORD_BYTE, rd_byte, POS_W'(rec_idx)};
          out_last_val = 1'b0;
          rec_idx_next = rec_idx + 6'd1;
          if (addr_k == ADDR_LAST) begin
            state_next = ST_CLOSE;
          end else begin
            addr_k_next = addr_k + 2'd1;
            state_next  = ST_ADDR_RD;
          end
        end
      end
      ST_CLOSE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_val    = result_t'{EV_RECORD_BYTE, CH_RPAR, POS_W'(rec_idx)};
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= START_RESET;
      end_byte   <= END_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_START: start_byte <= cfg_data;
        CFG_END:   end_byte   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reply_phase  <= RP_IDLE;
      disc_phase   <= DP_NONE;
      target_len   <= '0;
      reply_index  <= '0;
      frame_active <= 1'b0;
      frame_count  <= '0;
      frame_len    <= '0;
    end else if (accept) begin
      reply_phase  <= reply_phase_next;
      disc_phase   <= disc_phase_next;
      target_len   <= target_len_next;
      reply_index  <= reply_index_next;
      frame_active <= frame_active_next;
      frame_count  <= frame_count_next;
      frame_len    <= frame_len_next;
    end
  end

  // store: written only on accepted words, read only while input is held off
  always_ff @(posedge clk) begin
    if (mem_we) store_mem[mem_waddr] <= b;
    if (rd_en) begin
      rd_data <= store_mem[rd_addr];
      rd_vld  <= store_vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store_vld <= '0;
    end else if (mem_we) begin
      store_vld[mem_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx  <= chk_idx_next;
    mism     <= mism_next;
    done_pos <= done_pos_next;
    name_ptr <= name_ptr_next;
    rec_idx  <= rec_idx_next;
    addr_k   <= addr_k_next;
    if (pend_load) pend <= r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_q      <= out_val;
      out_last_q <= out_last_val;
    end
  end

endmodule

// ===== design/brfr_checker.sv =====
`include "assert_macros.svh"

module brfr_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [brfr_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [brfr_pkg::OUT_TUSER_W-1:0] m_tuser,
  input logic                             m_tlast
);
  import brfr_pkg::*;

  // stalled word holds
  `ASSERT_CLK_RST(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")

  // no input taken while a record is still streaming out
  `ASSERT_CLK_RST(a_record_blocks, clk, rst, m_tvalid && m_tuser == EV_RECORD_BYTE && !m_tlast |-> !s_tready, "input accepted during record")

  // done events always close the results of their word
  `ASSERT_CLK_RST(a_done_last, clk, rst, m_tvalid && (m_tuser == EV_FRAME_DONE || m_tuser == EV_MSG_DONE) |-> m_tlast, "done event not marked last")

  // reset empties the output register
  `ASSERT_CLK(a_rst_clear, clk, rst |=> !m_tvalid, "output valid after reset")

endmodule

bind ble_reply_and_frame_receiver_unit brfr_checker u_brfr_checker (.*);
